// ----- src/btb_lru_pkg.sv -----
// Shared constants, codes and cell interface types for the branch target buffer.
package btb_lru_pkg;

    localparam int unsigned ENTRIES    = 16;
    localparam int unsigned ADDR_BITS  = 32;
    // Fixed port widths
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned OUT_SLOT_W = 4;
    // Stored address width: addresses are taken modulo 2^ADDR_BITS
    localparam int unsigned ADDR_W     = (ADDR_BITS < DATA_W) ? ADDR_BITS : DATA_W;
    localparam int unsigned SLOT_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned RANK_W     = SLOT_W;
    // Touch rank can be ENTRIES itself (fill into a free slot)
    localparam int unsigned ORANK_W    = $clog2(ENTRIES + 1);

    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_UPDATE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    typedef struct packed {
        logic               touch;      // recency update this cycle
        logic               sel;        // this cell becomes most recent
        logic               write;      // load tag, target, taken
        logic               set_taken;  // rewrite taken bit only
        logic [ORANK_W-1:0] old_rank;   // rank of the touched entry
    } t_cell_ctl;

    typedef struct packed {
        logic              valid;
        logic              match;
        logic              victim;      // holds the oldest rank
        logic              free_first;  // lowest free slot
        logic [RANK_W-1:0] rank;
        logic [ADDR_W-1:0] target;
        logic              taken;
    } t_cell_stat;

endpackage

// ----- src/btb_lru_cell.sv -----
// One buffer entry: tag compare, payload storage and LRU rank counter.
module btb_lru_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_prev_valid,
    input  logic [btb_lru_pkg::ADDR_W-1:0] i_tag,
    input  logic [btb_lru_pkg::ADDR_W-1:0] i_target,
    input  logic                          i_taken,
    input  btb_lru_pkg::t_cell_ctl        i_ctl,
    output btb_lru_pkg::t_cell_stat       o_stat
);

    logic                          r_valid;
    logic [btb_lru_pkg::ADDR_W-1:0] r_tag;
    logic [btb_lru_pkg::ADDR_W-1:0] r_target;
    logic                          r_taken;
    logic [btb_lru_pkg::RANK_W-1:0] r_rank;
    logic                          younger;

    // Younger than the touched entry: ages by one
    assign younger = r_valid &&
        ({1'b0, r_rank} < btb_lru_pkg::ORANK_W'(i_ctl.old_rank));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else begin
            if (i_ctl.write) begin
                r_valid <= 1'b1;
            end
            if (i_ctl.touch) begin
                if (i_ctl.sel) begin
                    r_rank <= '0;
                end else if (younger) begin
                    r_rank <= r_rank + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.write) begin
            r_tag    <= i_tag;
            r_target <= i_target;
            r_taken  <= i_taken;
        end else if (i_ctl.set_taken) begin
            r_taken <= i_taken;
        end
    end

    always_comb begin
        o_stat            = '0;
        o_stat.valid      = r_valid;
        o_stat.match      = r_valid && (r_tag == i_tag);
        o_stat.victim     = r_valid && (r_rank == btb_lru_pkg::RANK_W'(btb_lru_pkg::ENTRIES - 1));
        // Valid slots form a prefix, so the first free one follows a valid neighbor
        o_stat.free_first = !r_valid && i_prev_valid;
        o_stat.rank       = r_rank;
        o_stat.target     = r_target;
        o_stat.taken      = r_taken;
    end

endmodule

// ----- src/branch_target_buffer_lru_top.sv -----
// Top level of the fully associative branch target buffer with true LRU replacement.
//
// Command channel: i_action, i_source_address, i_target_in and i_taken_in; the
//   transfer happens at the rising edge where start is high and busy is low.
// Result channel: o_valid strobes for exactly one cycle with o_hit,
//   o_predicted_taken, o_target_address and o_slot. The receiver cannot stall;
//   the result is transferred at the edge that ends that cycle.
// Timing: the command is captured at the accepting edge; the row of cells compares
//   and updates in the execute state that follows (busy high), and the result
//   registers load as that state ends. The result is then on the ports with busy low,
//   and the edge that transfers it can also accept the next command. busy blocks the
//   input during the execute state, so a new command is not taken before the last is done.
// Structure: a row of ENTRIES identical cells, each with its own tag compare and
//   rank counter; each cell hands its valid bit to its neighbor to find the
//   lowest free slot. When full, the victim is the cell holding the oldest rank.
// Reset: i_rst_n (synchronous, active low) empties the buffer and clears all
//   ranks; no clearing pass is needed, the first command is taken right after.
module branch_target_buffer_lru_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_action,
    input  logic [31:0] i_source_address,
    input  logic [31:0] i_target_in,
    input  logic        i_taken_in,
    output logic        o_valid,
    output logic        o_hit,
    output logic        o_predicted_taken,
    output logic [31:0] o_target_address,
    output logic [3:0]  o_slot
);

    localparam int unsigned N = btb_lru_pkg::ENTRIES;

    btb_lru_pkg::t_state r_state, n_state;

    // Captured command
    logic                           r_action;
    logic [btb_lru_pkg::ADDR_W-1:0] r_tag;
    logic [btb_lru_pkg::ADDR_W-1:0] r_target;
    logic                           r_taken;

    // Result registers
    logic                           r_valid;
    logic                           r_hit;
    logic                           r_pred;
    logic [btb_lru_pkg::ADDR_W-1:0] r_out_target;
    logic [btb_lru_pkg::SLOT_W-1:0] r_slot;

    btb_lru_pkg::t_cell_stat stat [N];
    btb_lru_pkg::t_cell_ctl  ctl  [N];

    logic                            accept;
    logic                            exec;
    logic                            is_update;
    logic [N-1:0]                    match_v;
    logic [N-1:0]                    victim_v;
    logic [N-1:0]                    free_v;
    logic [N-1:0]                    ins_v;
    logic [N-1:0]                    sel_v;
    logic                            found;
    logic                            full;
    logic                            insert;
    logic                            touch;
    logic [btb_lru_pkg::ORANK_W-1:0] old_rank;
    logic [btb_lru_pkg::ADDR_W-1:0]  hit_target;
    logic                            hit_taken;
    logic [btb_lru_pkg::SLOT_W-1:0]  sel_slot;
    logic                            n_hit;
    logic                            n_pred;
    logic [btb_lru_pkg::ADDR_W-1:0]  n_out_target;

    assign busy      = (r_state == btb_lru_pkg::ST_EXEC);
    assign accept    = start && !busy;
    assign exec      = (r_state == btb_lru_pkg::ST_EXEC);
    assign is_update = (r_action == btb_lru_pkg::ACT_UPDATE);

    always_comb begin
        case (r_state)
            btb_lru_pkg::ST_IDLE: n_state = accept ? btb_lru_pkg::ST_EXEC
                                                   : btb_lru_pkg::ST_IDLE;
            btb_lru_pkg::ST_EXEC: n_state = btb_lru_pkg::ST_IDLE;
            default:              n_state = btb_lru_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= btb_lru_pkg::ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_action;
            r_tag    <= i_source_address[btb_lru_pkg::ADDR_W-1:0];
            r_target <= i_target_in[btb_lru_pkg::ADDR_W-1:0];
            r_taken  <= i_taken_in;
        end
        if (exec) begin
            r_hit        <= n_hit;
            r_pred       <= n_pred;
            r_out_target <= n_out_target;
            r_slot       <= sel_slot;
        end
    end

    // Row of cells; each passes its valid bit to the next
    for (genvar g = 0; g < N; g++) begin : g_cell
        logic prev_valid;
        if (g == 0) begin : g_head
            assign prev_valid = 1'b1;
        end else begin : g_link
            assign prev_valid = stat[g-1].valid;
        end
        btb_lru_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_prev_valid(prev_valid),
            .i_tag       (r_tag),
            .i_target    (r_target),
            .i_taken     (r_taken),
            .i_ctl       (ctl[g]),
            .o_stat      (stat[g])
        );
    end

    // Gather status; tags of valid entries are unique, so at most one match
    always_comb begin
        match_v  = '0;
        victim_v = '0;
        free_v   = '0;
        for (int i = 0; i < N; i++) begin
            match_v[i]  = stat[i].match;
            victim_v[i] = stat[i].victim;
            free_v[i]   = stat[i].free_first;
        end
        found  = |match_v;
        full   = stat[N-1].valid;
        insert = exec && is_update && !found;
        ins_v  = full ? victim_v : free_v;
        sel_v  = found ? match_v : (insert ? ins_v : '0);
        touch  = exec && (is_update ? !found : found);
    end

    // One-hot selects of rank, payload and slot number
    always_comb begin
        old_rank   = '0;
        hit_target = '0;
        hit_taken  = 1'b0;
        sel_slot   = '0;
        for (int i = 0; i < N; i++) begin
            if (sel_v[i]) begin
                old_rank = old_rank | btb_lru_pkg::ORANK_W'(stat[i].rank);
                sel_slot = sel_slot | btb_lru_pkg::SLOT_W'(i);
            end
            if (match_v[i]) begin
                hit_target = hit_target | stat[i].target;
                hit_taken  = hit_taken | stat[i].taken;
            end
        end
        // Fill into a free slot: every valid entry ages
        if (insert && !full) begin
            old_rank = btb_lru_pkg::ORANK_W'(N);
        end
    end

    always_comb begin
        for (int i = 0; i < N; i++) begin
            ctl[i]           = '0;
            ctl[i].touch     = touch;
            ctl[i].sel       = sel_v[i];
            ctl[i].write     = insert && ins_v[i];
            ctl[i].set_taken = exec && is_update && match_v[i];
            ctl[i].old_rank  = old_rank;
        end
    end

    // Update always reports the taken bit it stored
    assign n_hit        = found;
    assign n_pred       = is_update ? r_taken : (found && hit_taken);
    assign n_out_target = found ? hit_target : (is_update ? r_target : '0);

    assign o_valid           = r_valid;
    assign o_hit             = r_hit;
    assign o_predicted_taken = r_pred;
    assign o_target_address  = 32'(r_out_target);
    assign o_slot            = btb_lru_pkg::OUT_SLOT_W'(r_slot);

endmodule

// ----- src/btb_lru_checker.sv -----
// Port-level timing checks for the branch target buffer, bound to the top level.
module btb_lru_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    a_busy_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy && o_valid)
        else $error("execute cycle not followed by result strobe");

    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without execute cycle");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

endmodule

bind branch_target_buffer_lru_top btb_lru_checker u_btb_lru_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .start  (start),
    .busy   (busy),
    .o_valid(o_valid)
);
